// ----- sv/cps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour palette store package
// Shared widths, codes and constants of the colour palette store.
// ----------------------------------------------------------------------------
package cps_pkg;

	// Default number of palette entries.
	localparam int unsigned PALETTE_ENTRIES_DEF = 256;

	// Word field widths.
	localparam int unsigned IDX_W   = 8;
	localparam int unsigned COMP_W  = 16;
	localparam int unsigned TRANS_W = 17;
	localparam int unsigned ENTRY_W = 32;
	localparam int unsigned LEVEL_W = 4;

	// Configuration port widths.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 4;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FORMAT     = 2'd0,
		CFG_BLEND_ZERO = 2'd1,
		CFG_BLEND_ONE  = 2'd2
	} cfg_reg_t;

	// Function codes of an input word.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	// Entry format codes.
	localparam logic FMT_16 = 1'b0;
	localparam logic FMT_32 = 1'b1;

	// Fully transparent marker of the 16-bit format and its read transparency.
	localparam logic [15:0]        FMT16_MARKER  = 16'hfc0f;
	localparam logic [TRANS_W-1:0] MARKER_TRANS  = 17'h000ff;

	// Register reset values.
	localparam logic [LEVEL_W-1:0] BLEND_ZERO_RST = 4'd0;
	localparam logic [LEVEL_W-1:0] BLEND_ONE_RST  = 4'd4;

endpackage

// ----- sv/cps_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour palette store request channel
// Valid/ready channel that carries one write or read request word.
// ----------------------------------------------------------------------------
interface cps_req_if;
	import cps_pkg::*;

	logic               valid;
	logic               ready;
	logic               func;
	logic [IDX_W-1:0]   entry_index;
	logic [COMP_W-1:0]  red_in;
	logic [COMP_W-1:0]  green_in;
	logic [COMP_W-1:0]  blue_in;
	logic [COMP_W-1:0]  transparency_in;

	modport source (
		output valid, func, entry_index, red_in, green_in, blue_in, transparency_in,
		input  ready
	);

	modport sink (
		input  valid, func, entry_index, red_in, green_in, blue_in, transparency_in,
		output ready
	);

endinterface

// ----- sv/cps_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour palette store response channel
// Valid/ready channel that carries one unpacked palette entry word.
// ----------------------------------------------------------------------------
interface cps_rsp_if;
	import cps_pkg::*;

	logic               valid;
	logic               ready;
	logic [COMP_W-1:0]  red_out;
	logic [COMP_W-1:0]  green_out;
	logic [COMP_W-1:0]  blue_out;
	logic [TRANS_W-1:0] transparency_out;

	modport source (
		output valid, red_out, green_out, blue_out, transparency_out,
		input  ready
	);

	modport sink (
		input  valid, red_out, green_out, blue_out, transparency_out,
		output ready
	);

endinterface

// ----- sv/colour_palette_format_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour palette format store
// Palette table with 16-bit RGB555 and 32-bit ARGB8888 entry formats.
// ----------------------------------------------------------------------------
// The block takes one request word per clock cycle, writes or reads alike,
// while the response side does not stall it. A write packs the colour in
// the current format and lands in the palette memory at the acceptance
// edge; it gives no response. A read gives one response word after the
// registered read port of the palette memory and the unpacking into the
// result register. The palette memory is not cleared by reset, so an
// entry must be written before it is read. Configuration writes are meant
// for idle periods, when no read response is still pending.
// ----------------------------------------------------------------------------
module colour_palette_format_store #(
	parameter int unsigned PALETTE_ENTRIES = cps_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	cps_req_if.sink                        req,
	cps_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [cps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cps_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cps_pkg::*;

	localparam int unsigned        ADDR_W    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [IDX_W:0]     ENTRIES_N = (IDX_W+1)'(PALETTE_ENTRIES);

	// Configuration registers.
	logic               format_q;
	logic [LEVEL_W-1:0] blend_zero_q;
	logic [LEVEL_W-1:0] blend_one_q;

	// Palette memory and read stage.
	logic [ENTRY_W-1:0] palette_q [PALETTE_ENTRIES];
	logic [ENTRY_W-1:0] rdata_s1;
	logic               valid_s1;
	logic               in_range_s1;

	// Result register.
	logic               rsp_valid_q;
	logic [COMP_W-1:0]  red_q;
	logic [COMP_W-1:0]  green_q;
	logic [COMP_W-1:0]  blue_q;
	logic [TRANS_W-1:0] trans_q;

	// Request side.
	logic               req_accept;
	logic               in_range;
	logic [ADDR_W-1:0]  addr;
	logic               wr_en;
	logic               rd_en;
	logic [ENTRY_W-1:0] wr_word;
	logic               adv_s1;

	// Unpacked entry.
	logic [15:0]        low_half;
	logic [COMP_W-1:0]  red_d;
	logic [COMP_W-1:0]  green_d;
	logic [COMP_W-1:0]  blue_d;
	logic [TRANS_W-1:0] trans_d;
	logic [LEVEL_W-1:0] level;

	// Packs a colour into the 16-bit format, with the transparent marker.
	function automatic logic [ENTRY_W-1:0] pack16(
		input logic [COMP_W-1:0] r,
		input logic [COMP_W-1:0] g,
		input logic [COMP_W-1:0] b,
		input logic [COMP_W-1:0] t
	);
		logic [ENTRY_W-1:0] word;
		if (t[15]) begin
			word = {16'h0000, FMT16_MARKER};
		end else begin
			word = {16'h0000, t[14], r[15:11], g[15:11], b[15:11]};
		end
		return word;
	endfunction

	// Packs a colour into the 32-bit format, transparency in the top byte.
	function automatic logic [ENTRY_W-1:0] pack32(
		input logic [COMP_W-1:0] r,
		input logic [COMP_W-1:0] g,
		input logic [COMP_W-1:0] b,
		input logic [COMP_W-1:0] t
	);
		return {t[15:8], r[15:8], g[15:8], b[15:8]};
	endfunction

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q     <= FMT_16;
			blend_zero_q <= BLEND_ZERO_RST;
			blend_one_q  <= BLEND_ONE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FORMAT:     format_q     <= cfg_data[0];
				CFG_BLEND_ZERO: blend_zero_q <= cfg_data;
				CFG_BLEND_ONE:  blend_one_q  <= cfg_data;
				default:        ;
			endcase
		end
	end

	// The read stage moves on when the result register is free or drains.
	assign adv_s1     = !rsp_valid_q || rsp.ready;
	assign req.ready  = !valid_s1 || adv_s1;
	assign req_accept = req.valid && req.ready;

	// Index check and memory controls.
	assign in_range = {1'b0, req.entry_index} < ENTRIES_N;
	assign addr     = req.entry_index[ADDR_W-1:0];
	assign wr_en    = req_accept && (req.func == FUNC_WRITE) && in_range;
	assign rd_en    = req_accept && (req.func == FUNC_READ) && in_range;
	assign wr_word  = (format_q == FMT_32)
		? pack32(req.red_in, req.green_in, req.blue_in, req.transparency_in)
		: pack16(req.red_in, req.green_in, req.blue_in, req.transparency_in);

	// Palette memory with one write port and a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			palette_q[addr] <= wr_word;
		end
		if (rd_en) begin
			rdata_s1 <= palette_q[addr];
		end
	end

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			in_range_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1    <= req.valid && (req.func == FUNC_READ);
			in_range_s1 <= in_range;
		end
	end

	// Unpack the stored word in the current format.
	assign low_half = rdata_s1[15:0];
	assign level    = low_half[15] ? blend_one_q : blend_zero_q;

	always_comb begin
		red_d   = '0;
		green_d = '0;
		blue_d  = '0;
		trans_d = '0;
		if (in_range_s1) begin
			if (format_q == FMT_32) begin
				trans_d = {1'b0, rdata_s1[31:24], 8'h00};
				red_d   = {rdata_s1[23:16], 8'h00};
				green_d = {rdata_s1[15:8], 8'h00};
				blue_d  = {rdata_s1[7:0], 8'h00};
			end else if (low_half == FMT16_MARKER) begin
				trans_d = MARKER_TRANS;
			end else begin
				red_d   = {low_half[14:10], 11'h000};
				green_d = {low_half[9:5], 11'h000};
				blue_d  = {low_half[4:0], 11'h000};
				trans_d = {level, 13'h0000};
			end
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
			trans_q <= trans_d;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.red_out          = red_q;
	assign rsp.green_out        = green_q;
	assign rsp.blue_out         = blue_q;
	assign rsp.transparency_out = trans_q;

`ifndef NO_ASSERTIONS
	// An accepted read occupies the read stage in the next cycle.
	a_read_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(req_accept && req.func == FUNC_READ) |=> valid_s1)
		else $error("accepted read did not enter the read stage");

	// A write into an empty read stage leaves it empty.
	a_write_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(req_accept && req.func == FUNC_WRITE && !valid_s1) |=> !valid_s1)
		else $error("write produced a read stage word");

	// A read word moving on always makes the result register valid.
	a_stage_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1) |=> rsp_valid_q)
		else $error("read stage word lost on its way to the result register");

	// An out-of-range read gives an all-zero response word.
	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1 && !in_range_s1) |=>
		(red_q == '0 && green_q == '0 && blue_q == '0 && trans_q == '0))
		else $error("out-of-range read gave a nonzero word");
`endif

endmodule
